@@ src/rcmc_pkg.sv @@
// Shared constants, types and helpers of the color correction matrix block.
package rcmc_pkg;

  localparam int COEF_WIDTH     = 16;
  localparam int COEF_FRAC_BITS = 12;

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int ROW_W      = 48;
  localparam int CLAMP_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam int COEFS_W = NUM_CH * COEF_WIDTH;
  localparam int EXT_W   = (COEFS_W > ROW_W) ? COEFS_W : ROW_W;
  localparam int PROD_W  = COEF_WIDTH + CH_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int BND_W   = CH_W + COEF_FRAC_BITS + 1;
  localparam int CMP_W   = (SUM_W > BND_W) ? SUM_W : BND_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_BLUE  = 3'd5;

  localparam logic [ROW_W-1:0]   COEF_RED_RST   = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0]   COEF_GREEN_RST = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0]   COEF_BLUE_RST  = 48'h1000_0000_0000;
  localparam logic [CLAMP_W-1:0] CLAMP_RST      = 16'hff00;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [CLAMP_W-1:0] bounds;
  } lane_cfg_t;

  function automatic logic signed [COEF_WIDTH-1:0] coef_at(
    input logic [ROW_W-1:0] row,
    input int unsigned      k
  );
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(row);
    return $signed(ext[k*COEF_WIDTH +: COEF_WIDTH]);
  endfunction

  function automatic logic [CH_W-1:0] pix_ch(
    input logic [PIX_W-1:0] pixel,
    input int unsigned      k
  );
    return pixel[(NUM_CH-1-k)*CH_W +: CH_W];
  endfunction

endpackage

@@ src/rcmc_lane.sv @@
// One output channel: multiply stage, then sum, clamp and truncate stage.
module rcmc_lane (
  input  logic                      clk,
  input  rcmc_pkg::lane_cfg_t       cfg,
  input  logic [rcmc_pkg::PIX_W-1:0] pixel,
  output logic [rcmc_pkg::CH_W-1:0]  chan
);
  import rcmc_pkg::*;

  logic signed [PROD_W-1:0] prod_r [NUM_CH];
  logic [CH_W-1:0]          chan_r;
  logic signed [CMP_W-1:0]  sum;
  logic signed [CMP_W-1:0]  lo;
  logic signed [CMP_W-1:0]  hi;
  logic signed [CMP_W-1:0]  clip_lo;
  logic signed [CMP_W-1:0]  clip;
  logic [CH_W-1:0]          chan_nxt;

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod_r[k] <= PROD_W'(coef_at(cfg.row, k)) *
                   PROD_W'($signed({1'b0, pix_ch(pixel, k)}));
    end
  end

  always_comb begin
    sum = CMP_W'(prod_r[0]) + CMP_W'(prod_r[1]) + CMP_W'(prod_r[2]);
    lo  = CMP_W'($signed({1'b0, cfg.bounds[CH_W-1:0], {COEF_FRAC_BITS{1'b0}}}));
    hi  = CMP_W'($signed({1'b0, cfg.bounds[2*CH_W-1:CH_W], {COEF_FRAC_BITS{1'b0}}}));
    clip_lo  = (sum < lo) ? lo : sum;
    clip     = (clip_lo > hi) ? hi : clip_lo;
    chan_nxt = clip[COEF_FRAC_BITS +: CH_W];
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
  end

  assign chan = chan_r;

endmodule

@@ src/rgb_color_matrix_clamp.sv @@
// Top level: config registers, three channel lanes and the output merge.
// Takes one pixel every clock and never raises busy. Each pixel comes out
// in input order, through the lane multiplier register, the lane sum and
// clamp register and the output merge register. out_valid marks each
// result for exactly one cycle; the receiver cannot stall it, so it must
// take every result as it comes. Config writes are always accepted
// (cfg_ready stays high) and take effect on the next cycle; write them
// only while no pixel is in flight.
module rgb_color_matrix_clamp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rcmc_pkg::PIX_W-1:0]      in_pixel,
  input  logic                            in_last,
  output logic                            out_valid,
  output logic [rcmc_pkg::PIX_W-1:0]      out_pixel,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcmc_pkg::*;

  logic [ROW_W-1:0]   coef_row_r [NUM_CH];
  logic [CLAMP_W-1:0] clamp_r    [NUM_CH];
  lane_cfg_t          lane_cfg   [NUM_CH];
  logic [CH_W-1:0]    chan       [NUM_CH];

  logic            accept;
  logic [1:0]      vld_r;
  logic [1:0]      last_r;
  logic            out_valid_r;
  logic            out_last_r;
  logic [PIX_W-1:0] out_pixel_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_row_r[0] <= COEF_RED_RST;
      coef_row_r[1] <= COEF_GREEN_RST;
      coef_row_r[2] <= COEF_BLUE_RST;
      for (int k = 0; k < NUM_CH; k++) begin
        clamp_r[k] <= CLAMP_RST;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COEF_RED:    coef_row_r[0] <= cfg_data[ROW_W-1:0];
        CFG_COEF_GREEN:  coef_row_r[1] <= cfg_data[ROW_W-1:0];
        CFG_COEF_BLUE:   coef_row_r[2] <= cfg_data[ROW_W-1:0];
        CFG_CLAMP_RED:   clamp_r[0]    <= cfg_data[CLAMP_W-1:0];
        CFG_CLAMP_GREEN: clamp_r[1]    <= cfg_data[CLAMP_W-1:0];
        CFG_CLAMP_BLUE:  clamp_r[2]    <= cfg_data[CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    assign lane_cfg[g].row    = coef_row_r[g];
    assign lane_cfg[g].bounds = clamp_r[g];

    rcmc_lane u_lane (
      .clk   (clk),
      .cfg   (lane_cfg[g]),
      .pixel (in_pixel),
      .chan  (chan[g])
    );
  end

  // advance valid and last alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[0], accept};
      out_valid_r <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= {last_r[0], in_last};
    out_last_r  <= last_r[1];
    out_pixel_r <= {chan[0], chan[1], chan[2]};
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) && $past(accept, 3)
      |-> out_valid)
    else $error("accepted item produced no result");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result without accepted item");

  a_upper_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel[23:16] <= clamp_r[0][15:8])
    else $error("red channel above upper bound");

  a_upper_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel[7:0] <= clamp_r[2][15:8])
    else $error("blue channel above upper bound");

endmodule
